FILE: src/slmu_pkg.sv
// slmu_pkg: shared constants, types and codes of the sorted list merge block
// no dependencies
package slmu_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_RUN    = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          is_last;
        logic                          is_empty;
        logic                          overflowed;
    } t_res;

endpackage

FILE: src/slmu_ram.sv
// slmu_ram: generic single write port, single read port ram with registered read
// no dependencies
module slmu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/slmu_out_reg.sv
// slmu_out_reg: output register holding one result item for the downstream side
// depends on slmu_pkg
module slmu_out_reg
    import slmu_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  t_res                          i_res,
    output logic                          o_slot_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_merged_value,
    output logic                          o_is_last,
    output logic                          o_is_empty,
    output logic                          o_overflowed
);

    logic r_valid;
    logic n_valid;
    t_res r_res;

    assign o_slot_free = !(r_valid && i_stall);

    always_comb begin
        n_valid = r_valid;
        if (o_slot_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_slot_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_merged_value = r_res.value;
    assign o_is_last      = r_res.is_last;
    assign o_is_empty     = r_res.is_empty;
    assign o_overflowed   = r_res.overflowed;

endmodule

FILE: src/slmu_core.sv
// slmu_core: load counters, store rams and the head-compare merge sequencer
// depends on slmu_pkg and slmu_ram
module slmu_core
    import slmu_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_mode,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_busy,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_keep_duplicates,
    input  logic                          i_slot_free,
    output logic                          o_load,
    output t_res                          o_res
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0] r_ia, n_ia, r_ib, n_ib;
    logic r_ovf, n_ovf;
    logic r_keep;
    logic r_have, n_have;
    logic signed [VALUE_WIDTH-1:0] r_pend, n_pend;
    logic we_a, we_b;
    logic [VALUE_WIDTH-1:0] q_a, q_b;
    logic signed [VALUE_WIDTH-1:0] a, b, v;
    logic have_a, have_b, take_a, take_b, emit;

    assign a      = $signed(q_a);
    assign b      = $signed(q_b);
    assign have_a = r_ia < r_cnt_a;
    assign have_b = r_ib < r_cnt_b;
    assign o_busy = r_state != ST_IDLE;

    // head selection
    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (have_a && have_b) begin
            if (r_keep) begin
                take_a = !(b < a);
                take_b = b < a;
            end else begin
                take_a = (a == b) || (a < b);
                take_b = (a == b) || !(a < b);
            end
        end else begin
            take_a = have_a;
            take_b = !have_a && have_b;
        end
        v    = take_a ? a : b;
        emit = r_keep || !r_have || (v != r_pend);
    end

    always_comb begin
        n_state = r_state;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_ia    = r_ia;
        n_ib    = r_ib;
        n_ovf   = r_ovf;
        n_have  = r_have;
        n_pend  = r_pend;
        we_a    = 1'b0;
        we_b    = 1'b0;
        o_load  = 1'b0;
        o_res   = '{value: r_pend, is_last: 1'b0, is_empty: 1'b0, overflowed: r_ovf};
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (t_mode'(i_mode))
                        MODE_LOAD_A: begin
                            if (r_cnt_a < CNT_W'(STORE_DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        MODE_LOAD_B: begin
                            if (r_cnt_b < CNT_W'(STORE_DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        MODE_RUN: begin
                            n_state = ST_MERGE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                if (i_slot_free) begin
                    if (have_a || have_b) begin
                        if (take_a) begin
                            n_ia = r_ia + CNT_W'(1);
                        end
                        if (take_b) begin
                            n_ib = r_ib + CNT_W'(1);
                        end
                        if (emit) begin
                            o_load = r_have;
                            n_pend = v;
                            n_have = 1'b1;
                        end
                    end else begin
                        o_load  = 1'b1;
                        o_res   = '{value: r_have ? r_pend : '0, is_last: 1'b1,
                                    is_empty: !r_have, overflowed: r_ovf};
                        n_state = ST_IDLE;
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_ia    = '0;
                        n_ib    = '0;
                        n_ovf   = 1'b0;
                        n_have  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ia    <= '0;
            r_ib    <= '0;
            r_ovf   <= 1'b0;
            r_have  <= 1'b0;
            r_keep  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ia    <= n_ia;
            r_ib    <= n_ib;
            r_ovf   <= n_ovf;
            r_have  <= n_have;
            if (i_cfg_we) begin
                r_keep <= i_cfg_keep_duplicates;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    slmu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STORE_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_ia[ADDR_W-1:0]),
        .o_rdata (q_a)
    );

    slmu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STORE_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_ib[ADDR_W-1:0]),
        .o_rdata (q_b)
    );

`ifndef NO_ASSERTIONS
    a_heads_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ia <= r_cnt_a) && (r_ib <= r_cnt_b))
        else $error("merge head beyond store fill");
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(STORE_DEPTH)) && (r_cnt_b <= CNT_W'(STORE_DEPTH)))
        else $error("store count beyond depth");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_ia == '0) && (r_ib == '0) && !r_have)
        else $error("merge state left over in idle");
    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> i_slot_free)
        else $error("result issued while output slot blocked");
    a_no_store_write_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> !we_a && !we_b)
        else $error("store written during merge");
`endif

endmodule

FILE: src/sorted_list_merge_union_top.sv
// sorted_list_merge_union_top: load items append to store a or b, a run item merges them.
// a load item is accepted only while no run is in progress, one load accepted per cycle.
// a run merges the store heads read through one read port of each store ram, holds while
// the output slot is blocked, and issues the last item once both stores have run out.
// reset: counts, overflow flag and keep_duplicates cleared; store contents not cleared.
// depends on slmu_pkg, slmu_core, slmu_out_reg
module sorted_list_merge_union_top
    import slmu_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_in_mode,
    input  logic signed [31:0]            i_in_element_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_keep_duplicates,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_out_merged_value,
    output logic                          o_out_is_last,
    output logic                          o_out_is_empty,
    output logic                          o_out_overflowed
);

    logic busy;
    logic slot_free;
    logic res_load;
    t_res res;

    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

    slmu_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_accept              (i_in_valid && !busy),
        .i_mode                (i_in_mode),
        .i_value               (i_in_element_value),
        .o_busy                (busy),
        .i_cfg_we              (i_cfg_valid),
        .i_cfg_keep_duplicates (i_cfg_keep_duplicates),
        .i_slot_free           (slot_free),
        .o_load                (res_load),
        .o_res                 (res)
    );

    slmu_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (res_load),
        .i_res          (res),
        .o_slot_free    (slot_free),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_merged_value (o_out_merged_value),
        .o_is_last      (o_out_is_last),
        .o_is_empty     (o_out_is_empty),
        .o_overflowed   (o_out_overflowed)
    );

endmodule
